### sv/nms_pkg.sv
`timescale 1ns / 1ps

package nms_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int AREA_W    = 2 * COORD_W;
    localparam int INDEX_W   = 13;
    localparam int THR_W     = 16;
    localparam int CFG_DATA_W = 16;

    // configuration register map
    localparam int REG_INDEX_W = 1;
    localparam logic [REG_INDEX_W-1:0] REG_IOU_THRESHOLD  = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_CLASS_AGNOSTIC = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    // default sizes
    localparam int MAX_KEPT_DEF  = 64;
    localparam int MAX_BOXES_DEF = 8192;
    localparam int QUEUE_DEPTH   = 2;

    // input item
    typedef struct packed {
        logic               frame_start;
        logic [COORD_W-1:0] left_edge;
        logic [COORD_W-1:0] top_edge;
        logic [COORD_W-1:0] right_edge;
        logic [COORD_W-1:0] bottom_edge;
        logic [LABEL_W-1:0] class_label;
    } in_item_t;

    // result item
    typedef struct packed {
        logic               keep;
        logic [INDEX_W-1:0] box_index;
        logic               table_overflow;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic               frame_start;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [LABEL_W-1:0] label;
        logic [AREA_W-1:0]  area;
        logic [INDEX_W-1:0] box_index;
    } job_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             agnostic;
    } cfg_t;

    // side length, zero when the side is inverted
    function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                 input logic [COORD_W-1:0] hi);
        span = (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

### sv/nms_fifo.sv
`timescale 1ns / 1ps

module nms_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = nms_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/nms_front.sv
`timescale 1ns / 1ps

module nms_front #(
    parameter int MAX_BOXES = nms_pkg::MAX_BOXES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  nms_pkg::in_item_t box,
    input  logic              q_full,
    output logic              q_push,
    output nms_pkg::job_t     job
);

    localparam int POS_W = $clog2(MAX_BOXES);

    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [POS_W-1:0]                    pos_cur;
    logic [POS_W+nms_pkg::INDEX_W-1:0]   pos_wide;
    logic [nms_pkg::COORD_W-1:0]         w, h;

    assign full   = q_full;
    assign q_push = push && !q_full;

    // position within the frame, restarted by frame_start
    assign pos_cur  = box.frame_start ? '0 : pos_reg;
    assign pos_next = (pos_cur == POS_W'(MAX_BOXES - 1)) ? '0 : pos_cur + 1'b1;
    assign pos_wide = {{nms_pkg::INDEX_W{1'b0}}, pos_cur};

    // box area
    assign w = nms_pkg::span(box.left_edge, box.right_edge);
    assign h = nms_pkg::span(box.top_edge, box.bottom_edge);

    always_comb
    begin
        job.frame_start = box.frame_start;
        job.x0          = box.left_edge;
        job.y0          = box.top_edge;
        job.x1          = box.right_edge;
        job.y1          = box.bottom_edge;
        job.label       = box.class_label;
        job.area        = nms_pkg::AREA_W'(w) * nms_pkg::AREA_W'(h);
        job.box_index   = pos_wide[nms_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (q_push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

### sv/nms_back.sv
`timescale 1ns / 1ps

module nms_back #(
    parameter int MAX_KEPT = nms_pkg::MAX_KEPT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nms_pkg::cfg_t      cfg,
    input  nms_pkg::job_t      job,
    input  logic               job_empty,
    output logic               job_pop,
    input  logic               res_full,
    output logic               res_push,
    output nms_pkg::out_item_t res
);

    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW    = nms_pkg::COORD_W;
    localparam int AW    = nms_pkg::AREA_W;
    localparam int UW    = AW + 1;
    localparam int PW    = UW + nms_pkg::THR_W;

    // kept table entry
    typedef struct packed {
        logic [CW-1:0]               x0;
        logic [CW-1:0]               y0;
        logic [CW-1:0]               x1;
        logic [CW-1:0]               y1;
        logic [nms_pkg::LABEL_W-1:0] label;
        logic [AW-1:0]               area;
    } kept_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    nms_pkg::job_t    cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             suppress_reg, suppress_next;

    kept_t            table_mem [MAX_KEPT];
    kept_t            rd_reg;
    kept_t            wr_entry;
    logic             issue, mem_we, busy;
    logic             keep, overflow;

    // comparison pipeline
    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic             m2_reg, m3_reg, m4_reg, m5_reg;
    logic [CW-1:0]    wx2_reg, wy2_reg;
    logic [AW-1:0]    karea2_reg, karea3_reg;
    logic [AW-1:0]    inter3_reg, inter4_reg;
    logic [UW-1:0]    union4_reg;
    logic [PW-1:0]    rhs5_reg;
    logic [PW-1:0]    lhs5_reg;
    logic [CW-1:0]    ix0, ix1, iy0, iy1;
    logic             match1;

    assign busy     = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign issue    = (state_reg == S_SCAN) && (idx_reg != count_reg);
    assign keep     = !suppress_reg;
    assign overflow = keep && (count_reg == CNT_W'(MAX_KEPT));
    assign mem_we   = (state_reg == S_DONE) && keep && !overflow;

    always_comb
    begin
        wr_entry.x0    = cur_reg.x0;
        wr_entry.y0    = cur_reg.y0;
        wr_entry.x1    = cur_reg.x1;
        wr_entry.y1    = cur_reg.y1;
        wr_entry.label = cur_reg.label;
        wr_entry.area  = cur_reg.area;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        suppress_next = suppress_reg;
        job_pop       = 1'b0;
        res_push      = 1'b0;
        res.keep           = keep;
        res.box_index      = cur_reg.box_index;
        res.table_overflow = overflow;

        if (v5_reg && m5_reg && (lhs5_reg > rhs5_reg))
        begin
            suppress_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!job_empty && !res_full)
                begin
                    job_pop       = 1'b1;
                    cur_next      = job;
                    idx_next      = '0;
                    suppress_next = 1'b0;
                    if (job.frame_start)
                    begin
                        count_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (!busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_push = 1'b1;
                if (mem_we)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            suppress_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            suppress_reg <= suppress_next;
            v1_reg       <= issue;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // kept table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (issue)
        begin
            rd_reg <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // overlap sides and label match
    assign ix0    = (cur_reg.x0 > rd_reg.x0) ? cur_reg.x0 : rd_reg.x0;
    assign ix1    = (cur_reg.x1 < rd_reg.x1) ? cur_reg.x1 : rd_reg.x1;
    assign iy0    = (cur_reg.y0 > rd_reg.y0) ? cur_reg.y0 : rd_reg.y0;
    assign iy1    = (cur_reg.y1 < rd_reg.y1) ? cur_reg.y1 : rd_reg.y1;
    assign match1 = cfg.agnostic || (rd_reg.label == cur_reg.label);

    // pipeline payload
    always_ff @(posedge clk)
    begin
        wx2_reg    <= nms_pkg::span(ix0, ix1);
        wy2_reg    <= nms_pkg::span(iy0, iy1);
        karea2_reg <= rd_reg.area;
        m2_reg     <= match1;

        inter3_reg <= AW'(wx2_reg) * AW'(wy2_reg);
        karea3_reg <= karea2_reg;
        m3_reg     <= m2_reg;

        union4_reg <= {1'b0, cur_reg.area} + {1'b0, karea3_reg} - {1'b0, inter3_reg};
        inter4_reg <= inter3_reg;
        m4_reg     <= m3_reg;

        rhs5_reg   <= PW'(cfg.threshold) * PW'(union4_reg);
        lhs5_reg   <= {1'b0, inter4_reg, {nms_pkg::THR_W{1'b0}}};
        m5_reg     <= m4_reg;
    end

endmodule

### sv/class_aware_box_nms.sv
`timescale 1ns / 1ps
// the back end handles one item at a time and takes the next only after pushing the result of the last
// each item is compared with every box in the kept table
// the back end scans one kept entry a cycle, then drains a five-stage compare pipeline
// the input side takes up to two items ahead while a box is still being scanned
// reset: queues empty, kept table empty, frame position zero, threshold 29491, agnostic off
// the kept table itself is not cleared; entries beyond the kept count are never read

module class_aware_box_nms #(
    parameter int MAX_KEPT  = nms_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = nms_pkg::MAX_BOXES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [nms_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [nms_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                push,
    output logic                                full,
    input  nms_pkg::in_item_t                   box,
    output logic                                empty,
    input  logic                                pop,
    output nms_pkg::out_item_t                  result
);

    localparam int JOB_W = $bits(nms_pkg::job_t);
    localparam int RES_W = $bits(nms_pkg::out_item_t);

    logic [nms_pkg::THR_W-1:0] thr_reg;
    logic                      agnostic_reg;
    nms_pkg::cfg_t             cfg;

    logic                      q_full, q_push, job_empty, job_pop;
    nms_pkg::job_t             job_in, job_out;
    logic [JOB_W-1:0]          job_out_bits;
    logic                      res_full, res_push;
    nms_pkg::out_item_t        res;
    logic [RES_W-1:0]          res_out_bits;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= nms_pkg::THR_RESET;
            agnostic_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nms_pkg::REG_IOU_THRESHOLD:  thr_reg      <= cfg_data[nms_pkg::THR_W-1:0];
                nms_pkg::REG_CLASS_AGNOSTIC: agnostic_reg <= cfg_data[0];
                default:                     thr_reg      <= thr_reg;
            endcase
        end
    end

    assign cfg.threshold = thr_reg;
    assign cfg.agnostic  = agnostic_reg;

    // front end: positions and areas
    nms_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .box    (box),
        .q_full (q_full),
        .q_push (q_push),
        .job    (job_in)
    );

    // queue between front and back
    nms_fifo #(
        .W     (JOB_W),
        .DEPTH (nms_pkg::QUEUE_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (job_pop),
        .rd_data (job_out_bits),
        .empty   (job_empty)
    );

    assign job_out = nms_pkg::job_t'(job_out_bits);

    // back end: scan of the kept table
    nms_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    nms_fifo #(
        .W     (RES_W),
        .DEPTH (nms_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out_bits),
        .empty   (empty)
    );

    assign result = nms_pkg::out_item_t'(res_out_bits);

    // back end only finishes an item into a free result slot
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // back end only takes an item that is waiting
    a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("item taken from an empty queue");

    // overflow only on a kept box
    a_ovf_keep: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res.keep || !res.table_overflow))
        else $error("overflow flagged on a suppressed box");

    // a taken item enters the scan state before its result is pushed
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> !res_push)
        else $error("result produced too early");

endmodule
